@@ src/lfss_pkg.sv @@
// Package with the shared constants and types of the largest free square scan core.
`default_nettype none

package lfss_pkg;

   // Line buffer depth and field widths.
   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int SIZE_W   = 11;
   localparam int WIDTH_W  = 11;
   localparam int BYTE_W   = 8;

   localparam logic [ROW_W-1:0]   ROW_LAST       = ROW_W'(MAX_ROWS - 1);
   localparam logic [WIDTH_W-1:0] WIDTH_MAX      = WIDTH_W'(MAX_COLS);
   localparam logic [WIDTH_W-1:0] WIDTH_RESET    = 11'd1024;
   localparam logic [BYTE_W-1:0]  FREE_CHAR_RESET = 8'd46;

   // Configuration register indexes (taken from paddr bit 2).
   typedef enum logic {
      REG_GRID_WIDTH = 1'b0,
      REG_FREE_CHAR  = 1'b1
   } lfss_reg_type;

   // Current configuration as seen by the datapath.
   typedef struct packed {
      logic [WIDTH_W-1:0] grid_width;
      logic [BYTE_W-1:0]  free_char;
   } lfss_cfg_type;

   // One cell waiting for its line buffer data.
   typedef struct packed {
      logic             is_free;
      logic             last;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } lfss_item_type;

endpackage

`default_nettype wire

@@ src/lfss_csr.sv @@
// Configuration register block of the largest free square scan core.
`default_nettype none

module lfss_csr
   import lfss_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output lfss_cfg_type      cfg
);

   logic [WIDTH_W-1:0] grid_width_ff;
   logic [BYTE_W-1:0]  free_char_ff;
   logic               write_en;
   lfss_reg_type       reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = lfss_reg_type'(csr_paddr[2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= WIDTH_RESET;
         free_char_ff  <= FREE_CHAR_RESET;
      end else if (write_en) begin
         case (reg_sel)
            REG_GRID_WIDTH: grid_width_ff <= csr_pwdata[WIDTH_W-1:0];
            REG_FREE_CHAR:  free_char_ff  <= csr_pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_GRID_WIDTH: csr_prdata = {{(32-WIDTH_W){1'b0}}, grid_width_ff};
         REG_FREE_CHAR:  csr_prdata = {{(32-BYTE_W){1'b0}}, free_char_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.grid_width = grid_width_ff;
   assign cfg.free_char  = free_char_ff;

endmodule

`default_nettype wire

@@ src/lfss_line_buf.sv @@
// Line buffer memory holding the square sizes of the previous grid row.
`default_nettype none

module lfss_line_buf
   import lfss_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [COL_W-1:0]  rd_addr,
   output logic [SIZE_W-1:0]      rd_data,
   input  wire logic              wr_en,
   input  wire logic [COL_W-1:0]  wr_addr,
   input  wire logic [SIZE_W-1:0] wr_data
);

   logic [SIZE_W-1:0] mem [MAX_COLS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ src/lfss_cell_calc.sv @@
// Square size update, best square tracking and result register.
`default_nettype none

module lfss_cell_calc
   import lfss_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire lfss_item_type     item,
   input  wire logic [SIZE_W-1:0] top_size,
   output logic                   item_fire,
   output logic [SIZE_W-1:0]      size_out,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [47:0]            rsp_tdata,
   output logic                   rsp_tlast
);

   logic [SIZE_W-1:0] left_ff,  left_in;
   logic [SIZE_W-1:0] diag_ff,  diag_in;
   logic [SIZE_W-1:0] best_ff,  best_in;
   logic [ROW_W-1:0]  best_r_ff, best_r_in;
   logic [COL_W-1:0]  best_c_ff, best_c_in;
   logic              out_valid_ff, out_valid_in;
   logic [SIZE_W-1:0] o_size_ff, o_best_ff;
   logic [ROW_W-1:0]  o_row_ff;
   logic [COL_W-1:0]  o_col_ff;
   logic              o_last_ff;
   logic [SIZE_W-1:0] min_tl, min_all, size_calc;
   logic [SIZE_W-1:0] new_best;
   logic [ROW_W-1:0]  new_r;
   logic [COL_W-1:0]  new_c;

   assign item_fire = item_valid & (~out_valid_ff | rsp_tready);

   always_comb begin
      min_tl  = (top_size < left_ff) ? top_size : left_ff;
      min_all = (diag_ff < min_tl) ? diag_ff : min_tl;
      if (!item.is_free) begin
         size_calc = '0;
      end else if (item.row == '0 || item.col == '0) begin
         size_calc = SIZE_W'(1);
      end else begin
         size_calc = min_all + SIZE_W'(1);
      end
      new_best = best_ff;
      new_r    = best_r_ff;
      new_c    = best_c_ff;
      if (item.is_free && size_calc > best_ff) begin
         new_best = size_calc;
         new_r    = item.row;
         new_c    = item.col;
      end
   end

   assign size_out = size_calc;

   always_comb begin
      left_in   = left_ff;
      diag_in   = diag_ff;
      best_in   = best_ff;
      best_r_in = best_r_ff;
      best_c_in = best_c_ff;
      if (item_fire) begin
         if (item.last) begin
            left_in   = '0;
            diag_in   = '0;
            best_in   = '0;
            best_r_in = '0;
            best_c_in = '0;
         end else begin
            left_in   = size_calc;
            diag_in   = top_size;
            best_in   = new_best;
            best_r_in = new_r;
            best_c_in = new_c;
         end
      end
      out_valid_in = item_fire | (out_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         diag_ff      <= '0;
         best_ff      <= '0;
         best_r_ff    <= '0;
         best_c_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         diag_ff      <= diag_in;
         best_ff      <= best_in;
         best_r_ff    <= best_r_in;
         best_c_ff    <= best_c_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_fire) begin
         o_size_ff <= size_calc;
         o_best_ff <= new_best;
         o_row_ff  <= new_r;
         o_col_ff  <= new_c;
         o_last_ff <= item.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {6'b0, o_col_ff, o_row_ff, o_best_ff, o_size_ff};

endmodule

`default_nettype wire

@@ src/largest_free_square_scan_core.sv @@
// Top level of the largest free square scan core.
`default_nettype none

// Channel  | Handshake             | Payload
// ---------+-----------------------+---------------------------------------------
// req      | req_tvalid/req_tready | tdata[7:0] cell_byte, tlast last_cell
// rsp      | rsp_tvalid/rsp_tready | tdata square_here, best_size, best_row,
//          |                       | best_col; tlast grid_done
// csr      | APB, pready tied high | 0x0 grid_width, 0x4 free_char
//
// One cell transaction is accepted per clock while the input is not stalled. The
// line buffer read is issued at acceptance and the cell is registered into the
// update stage; the size update then writes back and loads the result register,
// which offers the result. Reset is synchronous and clears the counters, the best
// square record and all valid flags; the line buffer is not cleared. A stalled
// result holds the update stage, and input stalls only while that stage is
// occupied and cannot move.

module largest_free_square_scan_core
   import lfss_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Input cells.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] cell_byte
   input  wire logic        req_tlast,
   // Results.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [10:0] square_here, [21:11] best_size,
                                         // [31:22] best_row, [41:32] best_col
   output logic             rsp_tlast,
   // Configuration.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   lfss_cfg_type      cfg;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              s1_valid_ff, s1_valid_in;
   lfss_item_type     s1_item_ff;
   logic              fwd_ff;
   logic [SIZE_W-1:0] fwd_data_ff;
   logic              accept;
   logic              s1_fire;
   logic [SIZE_W-1:0] s1_size;
   logic [SIZE_W-1:0] rd_data;
   logic [SIZE_W-1:0] top_size;
   logic [WIDTH_W-1:0] eff_width;
   logic [WIDTH_W-1:0] col_next;

   lfss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // A new cell enters when the update stage is empty or moving on this cycle.
   assign req_tready = ~s1_valid_ff | s1_fire;
   assign accept     = req_tvalid & req_tready;

   // Zero width acts as one column, anything past the buffer as the full buffer.
   always_comb begin
      if (cfg.grid_width == '0) begin
         eff_width = WIDTH_W'(1);
      end else if (cfg.grid_width > WIDTH_MAX) begin
         eff_width = WIDTH_MAX;
      end else begin
         eff_width = cfg.grid_width;
      end
   end

   // Raster position advances at acceptance, so the line buffer read for the
   // next cell can be issued right away.
   always_comb begin
      col_next = {1'b0, col_ff} + WIDTH_W'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (req_tlast) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next >= eff_width) begin
            col_in = '0;
            if (row_ff < ROW_LAST) begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
      s1_valid_in = accept | (s1_valid_ff & ~s1_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // The cell ahead writes its size in the same cycle that this cell reads the
   // buffer. When both hit the same column the memory returns stale data, so
   // the fresh size is captured here and used instead.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.is_free <= (req_tdata == cfg.free_char);
         s1_item_ff.last    <= req_tlast;
         s1_item_ff.row     <= row_ff;
         s1_item_ff.col     <= col_ff;
         fwd_ff             <= s1_fire && (s1_item_ff.col == col_ff);
         fwd_data_ff        <= s1_size;
      end
   end

   lfss_line_buf u_line_buf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (s1_fire),
      .wr_addr (s1_item_ff.col),
      .wr_data (s1_size)
   );

   assign top_size = fwd_ff ? fwd_data_ff : rd_data;

   lfss_cell_calc u_cell_calc (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff),
      .item       (s1_item_ff),
      .top_size   (top_size),
      .item_fire  (s1_fire),
      .size_out   (s1_size),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the largest free square scan core.
`timescale 1ns / 100ps

module tb_top;
   import lfss_pkg::*;

   // Expected content of one result transaction.
   typedef struct packed {
      logic [SIZE_W-1:0] square_here;
      logic [SIZE_W-1:0] best_size;
      logic [ROW_W-1:0]  best_row;
      logic [COL_W-1:0]  best_col;
      logic              grid_done;
   } scan_result_type;

   // Scoreboard: keeps its own copy of the scan state and configuration, works out the
   // result of every accepted cell and compares the results in order.
   class square_scoreboard;
      logic [WIDTH_W-1:0] width_reg;
      logic [BYTE_W-1:0]  free_reg;
      logic [SIZE_W-1:0]  line_sizes [MAX_COLS];
      logic [SIZE_W-1:0]  left_sz;
      logic [SIZE_W-1:0]  diag_sz;
      logic [SIZE_W-1:0]  best_side;
      logic [COL_W-1:0]   col_idx;
      logic [COL_W-1:0]   best_c;
      logic [ROW_W-1:0]   row_idx;
      logic [ROW_W-1:0]   best_r;
      scan_result_type    pending_squares [$];
      int unsigned        failures;
      int unsigned        checked;
      int unsigned        cols_seen;

      function new();
         width_reg = WIDTH_RESET;
         free_reg  = FREE_CHAR_RESET;
         foreach (line_sizes[i]) line_sizes[i] = '0;
         restart_grid();
         failures  = 0;
         checked   = 0;
         cols_seen = 0;
      endfunction

      function void restart_grid();
         left_sz   = '0;
         diag_sz   = '0;
         col_idx   = '0;
         row_idx   = '0;
         best_side = '0;
         best_r    = '0;
         best_c    = '0;
      endfunction

      function void set_reg(lfss_reg_type idx, logic [31:0] value);
         case (idx)
            REG_GRID_WIDTH: width_reg = value[WIDTH_W-1:0];
            REG_FREE_CHAR:  free_reg  = value[BYTE_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(lfss_reg_type idx);
         if (idx == REG_GRID_WIDTH) return 32'(width_reg);
         return 32'(free_reg);
      endfunction

      // Square size of one accepted cell, and the updated best square of the grid.
      function void note_cell(logic [BYTE_W-1:0] cell_byte, logic last);
         int unsigned     span;
         int unsigned     c;
         int unsigned     above;
         int unsigned     here;
         scan_result_type exp_res;
         // A width of zero behaves as one, anything past the line buffer as its depth.
         if (width_reg == '0) span = 1;
         else if (width_reg > WIDTH_MAX) span = MAX_COLS;
         else span = int'(width_reg);
         c     = int'(col_idx);
         if (c + 1 > cols_seen) cols_seen = c + 1;
         above = int'(line_sizes[c]);
         if (cell_byte == free_reg) begin
            if (row_idx == '0 || c == 0) begin
               here = 1;
            end else begin
               here = (above < int'(left_sz)) ? above : int'(left_sz);
               if (int'(diag_sz) < here) here = int'(diag_sz);
               here = here + 1;
            end
            // Only a strictly larger square moves the record, so ties keep the first.
            if (here > int'(best_side)) begin
               best_side = SIZE_W'(here);
               best_r    = row_idx;
               best_c    = COL_W'(c);
            end
         end else begin
            here = 0;
         end
         line_sizes[c] = SIZE_W'(here);
         diag_sz = SIZE_W'(above);
         left_sz = SIZE_W'(here);
         exp_res.square_here = SIZE_W'(here);
         exp_res.best_size   = best_side;
         exp_res.best_row    = best_r;
         exp_res.best_col    = best_c;
         exp_res.grid_done   = last;
         pending_squares.push_back(exp_res);
         if (last) begin
            restart_grid();
         end else if (c + 1 >= span) begin
            col_idx = '0;
            left_sz = '0;
            diag_sz = '0;
            if (row_idx != ROW_LAST) row_idx = row_idx + 1'b1;
         end else begin
            col_idx = COL_W'(c + 1);
         end
      endfunction

      task report(string line);
         failures++;
         if (failures <= 20) $display("MISMATCH: %s", line);
      endtask

      task check_result(logic [47:0] data, logic done);
         scan_result_type exp_res;
         if (pending_squares.size() == 0) begin
            report($sformatf("result %h/%b arrived with nothing pending", data, done));
            return;
         end
         exp_res = pending_squares.pop_front();
         checked++;
         if (data[10:0] !== exp_res.square_here)
            report($sformatf("result %0d square_here %0d, want %0d", checked, data[10:0],
                             exp_res.square_here));
         if (data[21:11] !== exp_res.best_size)
            report($sformatf("result %0d best_size %0d, want %0d", checked, data[21:11],
                             exp_res.best_size));
         if (data[31:22] !== exp_res.best_row)
            report($sformatf("result %0d best_row %0d, want %0d", checked, data[31:22],
                             exp_res.best_row));
         if (data[41:32] !== exp_res.best_col)
            report($sformatf("result %0d best_col %0d, want %0d", checked, data[41:32],
                             exp_res.best_col));
         if (done !== exp_res.grid_done)
            report($sformatf("result %0d grid_done %b, want %b", checked, done,
                             exp_res.grid_done));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] cell_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [10:0] square_here, [21:11] best_size,
                                  // [31:22] best_row, [41:32] best_col
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   square_scoreboard sb = new();

   // Pacing state. The calm flags give stretches with no idling on either side.
   bit              tx_calm = 1'b0;
   bit              rx_calm = 1'b0;
   bit              tx_up = 1'b0;     // req_tvalid is being held high for the next cell
   int unsigned     tx_gap = 0;
   int unsigned     rx_wait = 0;
   logic [7:0]      cur_free = FREE_CHAR_RESET;
   int unsigned     n_cells = 0;
   int unsigned     n_grids = 0;
   int unsigned     n_csr = 0;

   largest_free_square_scan_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Both channels are observed at the rising edge, before any nonblocking update of
   // that edge lands, so the sampled values are the ones the block saw.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) sb.note_cell(req_tdata, req_tlast);
      end
   end

   // Result side: after each accepted result transaction, tready may be dropped for a random hold.
   always @(posedge clock) begin : rx_pace
      int unsigned hold;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait    <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         hold = rx_calm ? 0 : $urandom_range(0, 9);
         if (hold != 0) begin
            rsp_tready <= 1'b0;
            rx_wait    <= hold;
         end
      end else if (!rsp_tready) begin
         if (rx_wait > 1) rx_wait <= rx_wait - 1;
         else rsp_tready <= 1'b1;
      end
   end

   // Hard stop in case a handshake never completes.
   initial begin : watchdog
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Sends one cell. The gap before the next cell is drawn at acceptance, so valid is
   // either kept high or lowered once in that step, never both.
   task automatic send_cell(logic [7:0] cell_byte, logic last);
      if (!tx_up) repeat (tx_gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= cell_byte;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      n_cells++;
      if (last) n_grids++;
      tx_gap = tx_calm ? 0 : $urandom_range(0, 9);
      tx_up  = (tx_gap == 0);
      if (!tx_up) req_tvalid <= 1'b0;
   endtask

   // Stops the input stream and waits until every pending result is back, then lets
   // the pipeline settle.
   task automatic settle();
      if (tx_up) begin
         req_tvalid <= 1'b0;
         tx_up = 1'b0;
      end
      do @(posedge clock); while (sb.pending_squares.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // APB write followed by a read back of the same register.
   task automatic csr_write(lfss_reg_type idx, logic [31:0] value);
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, value);
      if (idx == REG_FREE_CHAR) cur_free = value[7:0];
      n_csr++;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== sb.reg_value(idx))
         sb.report($sformatf("register %s reads %h, want %h", idx.name(), csr_prdata,
                             sb.reg_value(idx)));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [7:0] busy_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == cur_free);
      return b;
   endfunction

   function automatic logic [7:0] pick_cell(int unsigned free_pct);
      if ($urandom_range(0, 99) < free_pct) return cur_free;
      return busy_byte();
   endfunction

   initial begin : stimulus
      int unsigned i;
      int unsigned w;
      int unsigned eff;
      int unsigned n;
      int unsigned pct;
      int unsigned split;
      int unsigned sel;
      int unsigned cap;
      int unsigned rand_cells;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: the start of the first row of a 1024-cell wide grid.
      for (i = 0; i < 40; i++) send_cell(pick_cell(80), i == 39);

      // Width 0 acts as one column; free byte 0 next to the all-ones byte.
      settle();
      csr_write(REG_GRID_WIDTH, 32'd0);
      csr_write(REG_FREE_CHAR, 32'd0);
      send_cell(8'h00, 1'b0);
      send_cell(8'hFF, 1'b0);
      send_cell(8'h00, 1'b1);

      // All-free 2x3 grid: the second square of size 2 ties and must not win.
      settle();
      csr_write(REG_GRID_WIDTH, 32'd2);
      csr_write(REG_FREE_CHAR, 32'hFF);
      for (i = 0; i < 6; i++) send_cell(8'hFF, i == 5);

      // No free cell at all, grid closed in the middle of a row.
      settle();
      csr_write(REG_GRID_WIDTH, 32'd5);
      csr_write(REG_FREE_CHAR, 32'd46);
      send_cell(8'h23, 1'b0);
      send_cell(8'h00, 1'b0);
      send_cell(8'hFF, 1'b1);

      // Width beyond the line buffer is clamped to its depth.
      settle();
      csr_write(REG_GRID_WIDTH, 32'd2047);
      for (i = 0; i < 4; i++) send_cell(cur_free, i == 3);

      // Width shrinks below the current column mid-row, then grows again mid-row.
      settle();
      csr_write(REG_GRID_WIDTH, 32'd6);
      for (i = 0; i < 4; i++) send_cell(cur_free, 1'b0);
      settle();
      csr_write(REG_GRID_WIDTH, 32'd3);
      for (i = 0; i < 3; i++) send_cell(cur_free, 1'b0);
      settle();
      csr_write(REG_GRID_WIDTH, 32'd8);
      for (i = 0; i < 3; i++) send_cell(cur_free, i == 2);

      // Random grids: mostly small widths with dense free cells so squares grow, some
      // sparse noise grids, a few clamped widths, and occasional mid-grid changes.
      rand_cells = 0;
      while (rand_cells < 390) begin
         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm = ($urandom_range(0, 3) == 0);
         sel = $urandom_range(0, 99);
         if (sel < 5) w = 0;
         else if (sel < 10) w = $urandom_range(1024, 2047);
         else if (sel < 25) w = $urandom_range(11, 40);
         else w = $urandom_range(1, 10);
         eff = (w == 0) ? 1 : ((w > MAX_COLS) ? MAX_COLS : w);
         settle();
         csr_write(REG_GRID_WIDTH, w);
         if ($urandom_range(0, 1) == 1) csr_write(REG_FREE_CHAR, $urandom_range(0, 255));
         if (eff > 40) n = $urandom_range(1, 30);
         else n = eff * $urandom_range(1, 5) + $urandom_range(0, eff - 1);
         if (n > 90) n = 90;
         pct = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : $urandom_range(55, 97);
         split = (n > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, n - 1) : 0;
         for (i = 0; i < n; i++) begin
            // Mid-grid pause: the sender waits for every result; sometimes the
            // configuration changes while the grid is still open. A new width never
            // reaches past the columns visited since reset, so every line buffer
            // entry that a later row reads has been written.
            if (split != 0 && i == split) begin
               settle();
               sel = $urandom_range(0, 2);
               if (sel == 0) begin
                  cap = (sb.cols_seen < 12) ? sb.cols_seen : 12;
                  csr_write(REG_GRID_WIDTH, $urandom_range(0, cap));
               end else if (sel == 1) begin
                  csr_write(REG_FREE_CHAR, $urandom_range(0, 255));
               end
            end
            send_cell(pick_cell(pct), i == n - 1);
         end
         rand_cells += n;
      end

      settle();
      repeat (10) @(posedge clock);
      if (sb.pending_squares.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending_squares.size()));
      $display("Summary: %0d cells over %0d grids, %0d results compared, %0d register writes.",
               n_cells, n_grids, sb.checked, n_csr);
      $display("Covered widths 0 to 2047, mid-row width changes, mid-row grid ends and ties.");
      if (sb.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/lfss_pkg.sv
src/lfss_csr.sv
src/lfss_line_buf.sv
src/lfss_cell_calc.sv
src/largest_free_square_scan_core.sv
dv/tb_top.sv
